### src/scp_pkg.sv
// Package for the SPI port controller: widths, offsets, payload beats and state types.
// No dependencies; every module of the block refers to it by scoped names.
package scp_pkg;

    localparam int FIFO_DEPTH    = 8;
    localparam int PTR_W         = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W         = $clog2(FIFO_DEPTH + 1);
    localparam int HALF_DEPTH    = FIFO_DEPTH / 2;
    localparam logic [31:0] PERIPHERAL_ID = 32'd4264482;
    localparam logic [31:0] CELL_ID       = 32'd2986209805;

    localparam int WORD_W  = 16;
    localparam int CLK_W   = 20;
    localparam int PROD1_W = 13;
    localparam int PROD2_W = 22;

    localparam logic [1:0] OP_READ     = 2'd0;
    localparam logic [1:0] OP_WRITE    = 2'd1;
    localparam logic [1:0] OP_EXCHANGE = 2'd2;

    localparam logic [1:0] LEN_BYTE = 2'd1;
    localparam logic [1:0] LEN_HALF = 2'd2;
    localparam logic [1:0] LEN_BAD  = 2'd3;

    localparam logic [11:0] OFF_CTRL0   = 12'h000;
    localparam logic [11:0] OFF_CTRL1   = 12'h004;
    localparam logic [11:0] OFF_DATA    = 12'h008;
    localparam logic [11:0] OFF_STATUS  = 12'h00C;
    localparam logic [11:0] OFF_PRESC   = 12'h010;
    localparam logic [11:0] OFF_IMASK   = 12'h014;
    localparam logic [11:0] OFF_RAW     = 12'h018;
    localparam logic [11:0] OFF_MIS     = 12'h01C;
    localparam logic [11:0] OFF_ICLR    = 12'h020;
    localparam logic [11:0] OFF_DMA     = 12'h024;
    localparam logic [11:0] OFF_LIMIT   = 12'hFFC;
    localparam logic [7:0]  OFF_PID_HI  = 8'hFE;
    localparam logic [7:0]  OFF_CID_HI  = 8'hFF;

    localparam int CTRL1_ENABLE = 1;
    localparam logic [7:0] PRESC_WMASK   = 8'hFE;
    localparam logic [7:0] PRESC_DEFAULT = 8'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] offset;
        logic [1:0]  access_bytes;
        logic [15:0] write_data;
        logic [15:0] reply_word;
    } req_t;

    typedef struct packed {
        logic        response_error;
        logic [15:0] read_data;
        logic        frame_sent;
        logic [15:0] sent_word;
        logic [19:0] frame_clocks;
        logic        interrupt_line;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic mul;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic need_mul;
    } sts_t;

    function automatic logic [7:0] id_byte(input logic [31:0] id, input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = id[7:0];
            2'd1:    b = id[15:8];
            2'd2:    b = id[23:16];
            default: b = id[31:24];
        endcase
        return b;
    endfunction

    function automatic logic [15:0] frame_mask(input logic [3:0] size_m1);
        logic [4:0] bits;
        bits = {1'b0, size_m1} + 5'd1;
        return ~(16'hFFFF << bits);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

### src/scp_ctrl.sv
// Controller state machine for the SPI port controller: handshakes and sequencing.
// Depends on scp_pkg; drives the datapath through command and status structs.
module scp_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           request_valid,
    output logic           request_ready,
    output logic           response_valid,
    input  logic           response_ready,
    input  scp_pkg::sts_t  sts,
    output scp_pkg::cmd_t  cmd
);

    scp_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign slot_free = !out_valid_reg || response_ready;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        request_ready = 1'b0;
        unique case (state_reg)
            scp_pkg::ST_IDLE:
            begin
                request_ready = 1'b1;
                if (request_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = scp_pkg::ST_EXEC;
                end
            end
            scp_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.need_mul ? scp_pkg::ST_MUL : scp_pkg::ST_EMIT;
            end
            scp_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = scp_pkg::ST_EMIT;
            end
            default:
            begin
                if (slot_free)
                begin
                    cmd.emit      = 1'b1;
                    request_ready = 1'b1;
                    if (request_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = scp_pkg::ST_EXEC;
                    end
                    else
                    begin
                        state_next = scp_pkg::ST_IDLE;
                    end
                end
            end
        endcase

        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (response_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign response_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> response_valid)
        else $error("result not presented after emit");

    a_mul_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == scp_pkg::ST_MUL |-> $past(state_reg) == scp_pkg::ST_EXEC)
        else $error("multiply step without execute");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        request_valid && request_ready |=> state_reg == scp_pkg::ST_EXEC)
        else $error("accepted beat not executed");
`endif

endmodule

### src/scp_datapath.sv
// Datapath for the SPI port controller: register file, FIFOs, frame timing multiply.
// Depends on scp_pkg; steered by the command struct from scp_ctrl.
module scp_datapath
(
    input  logic           clk,
    input  logic           rst_n,
    input  scp_pkg::cmd_t  cmd,
    output scp_pkg::sts_t  sts,
    input  scp_pkg::req_t  request,
    output scp_pkg::rsp_t  response
);

    logic [15:0] tx_mem [scp_pkg::FIFO_DEPTH];
    logic [15:0] rx_mem [scp_pkg::FIFO_DEPTH];

    scp_pkg::req_t req_reg;
    scp_pkg::rsp_t res_reg, res_next;
    scp_pkg::rsp_t out_reg;
    scp_pkg::rsp_t emit_val;

    logic [15:0] cz_reg, cz_next;
    logic [3:0]  c1_reg, c1_next;
    logic [7:0]  ps_reg, ps_next;
    logic [3:0]  mask_reg, mask_next;
    logic        ovr_reg, ovr_next;
    logic [1:0]  dma_reg, dma_next;

    logic [scp_pkg::PTR_W-1:0] tx_head_reg, tx_tail_reg, rx_head_reg, rx_tail_reg;
    logic [scp_pkg::CNT_W-1:0] tx_cnt_reg, rx_cnt_reg;
    logic [15:0] tx_rd_reg, rx_rd_reg;
    logic [scp_pkg::PROD1_W-1:0] prod_reg;

    logic        tx_push, tx_pop, rx_push, rx_pop;
    logic        tx_empty, tx_full, rx_empty, rx_full, send, bad;
    logic [15:0] mask16, wr_val, rd_val, rx_word;
    logic [3:0]  raw;
    logic [4:0]  bits;
    logic [7:0]  ps_eff;
    logic [8:0]  scr;
    logic [scp_pkg::PROD2_W-1:0] prod2;

    assign tx_empty = tx_cnt_reg == '0;
    assign tx_full  = tx_cnt_reg == scp_pkg::CNT_W'(scp_pkg::FIFO_DEPTH);
    assign rx_empty = rx_cnt_reg == '0;
    assign rx_full  = rx_cnt_reg == scp_pkg::CNT_W'(scp_pkg::FIFO_DEPTH);
    assign mask16   = scp_pkg::frame_mask(cz_reg[3:0]);
    assign raw      = {tx_cnt_reg <= scp_pkg::CNT_W'(scp_pkg::HALF_DEPTH),
                       rx_cnt_reg >= scp_pkg::CNT_W'(scp_pkg::HALF_DEPTH),
                       1'b0, ovr_reg};
    assign send     = req_reg.operation == scp_pkg::OP_EXCHANGE && !tx_empty
                      && c1_reg[scp_pkg::CTRL1_ENABLE];
    assign bad      = req_reg.offset > scp_pkg::OFF_LIMIT
                      || req_reg.access_bytes == scp_pkg::LEN_BAD;
    assign sts.need_mul = send;
    assign rx_word  = req_reg.reply_word & mask16;

    assign bits   = {1'b0, cz_reg[3:0]} + 5'd1;
    assign ps_eff = (ps_reg == '0) ? scp_pkg::PRESC_DEFAULT : ps_reg;
    assign scr    = {1'b0, cz_reg[15:8]} + 9'd1;
    assign prod2  = scp_pkg::PROD2_W'(prod_reg) * scp_pkg::PROD2_W'(scr);

    always_comb
    begin
        priority if (req_reg.access_bytes == scp_pkg::LEN_HALF)
            wr_val = req_reg.write_data;
        else if (req_reg.access_bytes == scp_pkg::LEN_BYTE)
            wr_val = {8'h00, req_reg.write_data[7:0]};
        else
            wr_val = '0;
    end

    always_comb
    begin
        rd_val = '0;
        unique case (req_reg.offset)
            scp_pkg::OFF_CTRL0:  rd_val = cz_reg;
            scp_pkg::OFF_CTRL1:  rd_val = {12'h000, c1_reg};
            scp_pkg::OFF_DATA:   rd_val = rx_empty ? '0 : (rx_rd_reg & mask16);
            scp_pkg::OFF_STATUS: rd_val = {11'h000, !tx_empty, rx_full, !rx_empty,
                                           !tx_full, tx_empty};
            scp_pkg::OFF_PRESC:  rd_val = {8'h00, ps_reg};
            scp_pkg::OFF_IMASK:  rd_val = {12'h000, mask_reg};
            scp_pkg::OFF_RAW:    rd_val = {12'h000, raw};
            scp_pkg::OFF_MIS:    rd_val = {12'h000, raw & mask_reg};
            scp_pkg::OFF_DMA:    rd_val = {14'h0000, dma_reg};
            default:
            begin
                if (req_reg.offset[1:0] == 2'b00
                    && req_reg.offset[11:4] == scp_pkg::OFF_PID_HI)
                    rd_val = {8'h00, scp_pkg::id_byte(scp_pkg::PERIPHERAL_ID,
                                                      req_reg.offset[3:2])};
                else if (req_reg.offset[1:0] == 2'b00
                         && req_reg.offset[11:4] == scp_pkg::OFF_CID_HI)
                    rd_val = {8'h00, scp_pkg::id_byte(scp_pkg::CELL_ID,
                                                      req_reg.offset[3:2])};
            end
        endcase
    end

    always_comb
    begin
        cz_next   = cz_reg;
        c1_next   = c1_reg;
        ps_next   = ps_reg;
        mask_next = mask_reg;
        ovr_next  = ovr_reg;
        dma_next  = dma_reg;
        tx_push   = 1'b0;
        tx_pop    = 1'b0;
        rx_push   = 1'b0;
        rx_pop    = 1'b0;
        res_next  = '0;
        if (cmd.exec)
        begin
            if (req_reg.operation == scp_pkg::OP_EXCHANGE)
            begin
                if (send)
                begin
                    tx_pop             = 1'b1;
                    res_next.frame_sent = 1'b1;
                    res_next.sent_word  = tx_rd_reg;
                    if (rx_full)
                        ovr_next = 1'b1;
                    else
                        rx_push = 1'b1;
                end
            end
            else if (bad)
            begin
                res_next.response_error = 1'b1;
            end
            else if (req_reg.operation == scp_pkg::OP_READ)
            begin
                if (req_reg.offset == scp_pkg::OFF_DATA)
                begin
                    if (rx_empty)
                        ovr_next = 1'b1;
                    else
                        rx_pop = 1'b1;
                end
                priority if (req_reg.access_bytes == scp_pkg::LEN_HALF)
                    res_next.read_data = rd_val;
                else if (req_reg.access_bytes == scp_pkg::LEN_BYTE)
                    res_next.read_data = {8'h00, rd_val[7:0]};
                else
                    res_next.read_data = '0;
            end
            else if (req_reg.operation == scp_pkg::OP_WRITE)
            begin
                unique case (req_reg.offset)
                    scp_pkg::OFF_CTRL0: cz_next   = wr_val;
                    scp_pkg::OFF_CTRL1: c1_next   = wr_val[3:0];
                    scp_pkg::OFF_DATA:
                    begin
                        if (tx_full)
                            res_next.response_error = 1'b1;
                        else
                            tx_push = 1'b1;
                    end
                    scp_pkg::OFF_PRESC: ps_next   = wr_val[7:0] & scp_pkg::PRESC_WMASK;
                    scp_pkg::OFF_IMASK: mask_next = wr_val[3:0];
                    scp_pkg::OFF_ICLR:  ovr_next  = ovr_reg & !wr_val[0];
                    scp_pkg::OFF_DMA:   dma_next  = wr_val[1:0];
                    default:            res_next.response_error = 1'b1;
                endcase
            end
        end
    end

    always_comb
    begin
        emit_val                = res_reg;
        emit_val.interrupt_line = |(raw & mask_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cz_reg      <= '0;
            c1_reg      <= '0;
            ps_reg      <= '0;
            mask_reg    <= '0;
            ovr_reg     <= 1'b0;
            dma_reg     <= '0;
            tx_head_reg <= '0;
            tx_tail_reg <= '0;
            tx_cnt_reg  <= '0;
            rx_head_reg <= '0;
            rx_tail_reg <= '0;
            rx_cnt_reg  <= '0;
        end
        else
        begin
            cz_reg   <= cz_next;
            c1_reg   <= c1_next;
            ps_reg   <= ps_next;
            mask_reg <= mask_next;
            ovr_reg  <= ovr_next;
            dma_reg  <= dma_next;
            if (tx_push)
            begin
                tx_tail_reg <= scp_pkg::ptr_inc(tx_tail_reg);
                tx_cnt_reg  <= tx_cnt_reg + scp_pkg::CNT_W'(1);
            end
            else if (tx_pop)
            begin
                tx_head_reg <= scp_pkg::ptr_inc(tx_head_reg);
                tx_cnt_reg  <= tx_cnt_reg - scp_pkg::CNT_W'(1);
            end
            if (rx_push)
            begin
                rx_tail_reg <= scp_pkg::ptr_inc(rx_tail_reg);
                rx_cnt_reg  <= rx_cnt_reg + scp_pkg::CNT_W'(1);
            end
            else if (rx_pop)
            begin
                rx_head_reg <= scp_pkg::ptr_inc(rx_head_reg);
                rx_cnt_reg  <= rx_cnt_reg - scp_pkg::CNT_W'(1);
            end
        end
    end

    // FIFO storage; read ports sample the head every cycle
    always_ff @(posedge clk)
    begin
        if (tx_push)
            tx_mem[tx_tail_reg] <= wr_val;
        if (rx_push)
            rx_mem[rx_tail_reg] <= rx_word;
        tx_rd_reg <= tx_mem[tx_head_reg];
        rx_rd_reg <= rx_mem[rx_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= request;
        if (cmd.exec)
        begin
            res_reg  <= res_next;
            prod_reg <= scp_pkg::PROD1_W'(bits) * scp_pkg::PROD1_W'(ps_eff);
        end
        else if (cmd.mul)
        begin
            res_reg.frame_clocks <= prod2[scp_pkg::CLK_W-1:0];
        end
        if (cmd.emit)
            out_reg <= emit_val;
    end

    assign response = out_reg;

`ifndef NO_ASSERTIONS
    a_tx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tx_cnt_reg <= scp_pkg::CNT_W'(scp_pkg::FIFO_DEPTH))
        else $error("transmit level beyond depth");

    a_rx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rx_cnt_reg <= scp_pkg::CNT_W'(scp_pkg::FIFO_DEPTH))
        else $error("receive level beyond depth");

    a_mul_sent: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |-> res_reg.frame_sent && !res_reg.response_error)
        else $error("timing multiply for a beat that sent nothing");
`endif

endmodule

### src/spi_controller_registers_fifos.sv
// SPI port controller top level: register file, 8-deep transmit and receive FIFOs.
// Each accepted beat passes an execute state, then, for a sent frame, a multiply
// state (the frame time takes a second multiply step), then an emit state that
// loads the output register and accepts the next; a full output register stalls.
// Reset (rst_n, asynchronous): registers to reset values, FIFOs empty at once.
// Depends on scp_pkg, scp_ctrl and scp_datapath.
module spi_controller_registers_fifos
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           request_valid,
    output logic           request_ready,
    input  scp_pkg::req_t  request,
    output logic           response_valid,
    input  logic           response_ready,
    output scp_pkg::rsp_t  response
);

    scp_pkg::cmd_t cmd;
    scp_pkg::sts_t sts;

    scp_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .request_valid  (request_valid),
        .request_ready  (request_ready),
        .response_valid (response_valid),
        .response_ready (response_ready),
        .sts            (sts),
        .cmd            (cmd)
    );

    scp_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .request  (request),
        .response (response)
    );

endmodule

### tb/tb_spi_controller_registers_fifos.sv
// Testbench for spi_controller_registers_fifos: directed register, FIFO and frame tests,
// then random bus and frame traffic checked beat by beat against an in-bench predictor.
// Depends on scp_pkg and the spi_controller_registers_fifos RTL.
`timescale 1ns / 1ps

module tb_spi_controller_registers_fifos;

    localparam logic [1:0]  OP_NOP      = 2'd3;
    localparam logic [1:0]  LEN_NONE    = 2'd0;
    localparam logic [11:0] OFF_UNUSED  = 12'h028;
    localparam logic [11:0] OFF_PID0    = 12'hFE0;
    localparam logic [11:0] OFF_CID0    = 12'hFF0;
    localparam int          IRQ_OVERRUN = 0;
    localparam int          IRQ_RXLEVEL = 2;
    localparam int          IRQ_TXLEVEL = 3;
    localparam int          RANDOM_BEATS = 1450;
    localparam int          LONG_HOLD    = 300;
    localparam int          IDLE_LIMIT   = 2000;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          request_valid = 1'b0;
    logic          request_ready;
    scp_pkg::req_t request = '0;
    logic          response_valid;
    logic          response_ready = 1'b0;
    scp_pkg::rsp_t response;

    // predictor state
    logic [15:0] ctl0;
    logic [3:0]  ctl1;
    logic [7:0]  psc;
    logic [3:0]  imask;
    logic [3:0]  raw_irq;
    logic [1:0]  dma;
    logic [15:0] tx_words[$];
    logic [15:0] rx_words[$];

    scp_pkg::rsp_t awaited_responses[$];
    int  errors = 0;
    int  beats_sent = 0;
    int  idle_cycles = 0;
    bit  gaps_on = 1'b1;
    bit  stall_request = 1'b0;

    spi_controller_registers_fifos uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .request_valid  (request_valid),
        .request_ready  (request_ready),
        .request        (request),
        .response_valid (response_valid),
        .response_ready (response_ready),
        .response       (response)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void clear_model();
        ctl0 = '0;
        ctl1 = '0;
        psc = '0;
        imask = '0;
        raw_irq = 4'h8;
        dma = '0;
        tx_words.delete();
        rx_words.delete();
    endfunction

    function automatic logic [15:0] frame_bits_mask();
        logic [16:0] m;
        m = (17'd1 << ({1'b0, ctl0[3:0]} + 5'd1)) - 17'd1;
        return m[15:0];
    endfunction

    function automatic logic [15:0] register_value(input logic [11:0] off);
        logic [31:0] id;
        case (off)
            scp_pkg::OFF_CTRL0:  return ctl0;
            scp_pkg::OFF_CTRL1:  return {12'h0, ctl1};
            scp_pkg::OFF_DATA:
            begin
                if (rx_words.size() == 0)
                begin
                    raw_irq[IRQ_OVERRUN] = 1'b1;
                    return 16'h0;
                end
                return rx_words.pop_front() & frame_bits_mask();
            end
            scp_pkg::OFF_STATUS:
                return {11'h0, tx_words.size() != 0, rx_words.size() == scp_pkg::FIFO_DEPTH,
                        rx_words.size() != 0, tx_words.size() < scp_pkg::FIFO_DEPTH,
                        tx_words.size() == 0};
            scp_pkg::OFF_PRESC:  return {8'h0, psc};
            scp_pkg::OFF_IMASK:  return {12'h0, imask};
            scp_pkg::OFF_RAW:    return {12'h0, raw_irq};
            scp_pkg::OFF_MIS:    return {12'h0, raw_irq & imask};
            scp_pkg::OFF_DMA:    return {14'h0, dma};
            default:
            begin
                if (off[1:0] != 2'b00)
                    return 16'h0;
                if (off[11:4] == scp_pkg::OFF_PID_HI)
                    id = scp_pkg::PERIPHERAL_ID;
                else if (off[11:4] == scp_pkg::OFF_CID_HI)
                    id = scp_pkg::CELL_ID;
                else
                    return 16'h0;
                id = id >> {off[3:2], 3'b000};
                return {8'h0, id[7:0]};
            end
        endcase
    endfunction

    function automatic bit register_store(input logic [11:0] off, input logic [15:0] v);
        case (off)
            scp_pkg::OFF_CTRL0:  ctl0 = v;
            scp_pkg::OFF_CTRL1:  ctl1 = v[3:0];
            scp_pkg::OFF_DATA:
            begin
                if (tx_words.size() >= scp_pkg::FIFO_DEPTH)
                    return 1'b0;
                tx_words.push_back(v);
            end
            scp_pkg::OFF_PRESC:  psc = v[7:0] & scp_pkg::PRESC_WMASK;
            scp_pkg::OFF_IMASK:  imask = v[3:0];
            scp_pkg::OFF_ICLR:   raw_irq[1:0] = raw_irq[1:0] & ~v[1:0];
            scp_pkg::OFF_DMA:    dma = v[1:0];
            default:             return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic scp_pkg::rsp_t controller_response(input scp_pkg::req_t rq);
        scp_pkg::rsp_t r;
        logic [15:0]   v;
        int unsigned   nbits;
        int unsigned   ps;
        int unsigned   rate;
        int unsigned   clocks;
        r = '0;
        if (rq.operation == scp_pkg::OP_EXCHANGE)
        begin
            if (tx_words.size() != 0 && ctl1[scp_pkg::CTRL1_ENABLE])
            begin
                nbits = ctl0[3:0] + 1;
                ps = (psc != 0) ? psc : scp_pkg::PRESC_DEFAULT;
                rate = ctl0[15:8] + 1;
                clocks = nbits * ps * rate;
                r.frame_sent = 1'b1;
                r.sent_word = tx_words.pop_front();
                r.frame_clocks = clocks[19:0];
                if (rx_words.size() >= scp_pkg::FIFO_DEPTH)
                    raw_irq[IRQ_OVERRUN] = 1'b1;
                else
                    rx_words.push_back(rq.reply_word & frame_bits_mask());
            end
        end
        else if (rq.offset > scp_pkg::OFF_LIMIT || rq.access_bytes == scp_pkg::LEN_BAD)
            r.response_error = 1'b1;
        else if (rq.operation == scp_pkg::OP_READ)
        begin
            v = register_value(rq.offset);
            if (rq.access_bytes == scp_pkg::LEN_HALF)
                r.read_data = v;
            else if (rq.access_bytes == scp_pkg::LEN_BYTE)
                r.read_data = {8'h0, v[7:0]};
        end
        else if (rq.operation == scp_pkg::OP_WRITE)
        begin
            if (rq.access_bytes == scp_pkg::LEN_HALF)
                v = rq.write_data;
            else if (rq.access_bytes == scp_pkg::LEN_BYTE)
                v = {8'h0, rq.write_data[7:0]};
            else
                v = 16'h0;
            if (!register_store(rq.offset, v))
                r.response_error = 1'b1;
        end
        raw_irq[IRQ_TXLEVEL] = tx_words.size() <= scp_pkg::HALF_DEPTH;
        raw_irq[IRQ_RXLEVEL] = rx_words.size() >= scp_pkg::HALF_DEPTH;
        r.interrupt_line = |(raw_irq & imask);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_beat(input scp_pkg::req_t item);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            request_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        request <= item;
        request_valid <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (request_ready)
                break;
        end
        awaited_responses.push_back(controller_response(item));
        beats_sent++;
    endtask

    task automatic bus_read(input logic [11:0] off, input logic [1:0] len);
        scp_pkg::req_t rq;
        rq = '0;
        rq.operation = scp_pkg::OP_READ;
        rq.offset = off;
        rq.access_bytes = len;
        rq.write_data = 16'($urandom());
        rq.reply_word = 16'($urandom());
        send_beat(rq);
    endtask

    task automatic bus_write(input logic [11:0] off, input logic [1:0] len,
                             input logic [15:0] data);
        scp_pkg::req_t rq;
        rq = '0;
        rq.operation = scp_pkg::OP_WRITE;
        rq.offset = off;
        rq.access_bytes = len;
        rq.write_data = data;
        rq.reply_word = 16'($urandom());
        send_beat(rq);
    endtask

    task automatic exchange_frame(input logic [15:0] reply);
        scp_pkg::req_t rq;
        rq.operation = scp_pkg::OP_EXCHANGE;
        rq.offset = 12'($urandom());
        rq.access_bytes = 2'($urandom());
        rq.write_data = 16'($urandom());
        rq.reply_word = reply;
        send_beat(rq);
    endtask

    function automatic logic [11:0] random_offset();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 12'(4 * $urandom_range(0, 9));
        if (r < 70)
            return OFF_PID0 + 12'(4 * $urandom_range(0, 7));
        if (r < 80)
            return scp_pkg::OFF_LIMIT + 12'($urandom_range(1, 3));
        return 12'($urandom());
    endfunction

    function automatic logic [1:0] random_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return scp_pkg::LEN_HALF;
        if (r < 75)
            return scp_pkg::LEN_BYTE;
        if (r < 88)
            return LEN_NONE;
        return scp_pkg::LEN_BAD;
    endfunction

    task automatic send_random_access();
        scp_pkg::req_t rq;
        int r;
        r = $urandom_range(0, 99);
        rq.operation = (r < 40) ? scp_pkg::OP_READ : (r < 75) ? scp_pkg::OP_WRITE :
                       (r < 95) ? scp_pkg::OP_EXCHANGE : OP_NOP;
        rq.offset = random_offset();
        rq.access_bytes = random_length();
        rq.write_data = 16'($urandom());
        rq.reply_word = 16'($urandom());
        send_beat(rq);
    endtask

    task automatic run_frame_burst();
        logic [15:0] ctl;
        int pushes;
        int frames;
        int pops;
        ctl = 16'($urandom());
        bus_write(scp_pkg::OFF_CTRL0, scp_pkg::LEN_HALF, ctl);
        if ($urandom_range(0, 3) != 0)
            bus_write(scp_pkg::OFF_PRESC, scp_pkg::LEN_HALF,
                      ($urandom_range(0, 4) == 0) ? 16'h0 : 16'($urandom()));
        ctl = 16'($urandom());
        if ($urandom_range(0, 9) != 0)
            ctl[scp_pkg::CTRL1_ENABLE] = 1'b1;
        bus_write(scp_pkg::OFF_CTRL1, random_length() & scp_pkg::LEN_HALF, ctl);
        pushes = $urandom_range(1, 10);
        frames = $urandom_range(1, 10);
        pops = $urandom_range(0, 10);
        repeat (pushes)
        begin
            bus_write(scp_pkg::OFF_DATA,
                      ($urandom_range(0, 7) == 0) ? random_length() : scp_pkg::LEN_HALF,
                      16'($urandom()));
            if ($urandom_range(0, 9) == 0)
                send_random_access();
        end
        repeat (frames)
            exchange_frame(16'($urandom()));
        if ($urandom_range(0, 2) == 0)
            bus_read(scp_pkg::OFF_STATUS, scp_pkg::LEN_HALF);
        repeat (pops)
        begin
            bus_read(scp_pkg::OFF_DATA,
                     ($urandom_range(0, 5) == 0) ? random_length() : scp_pkg::LEN_HALF);
            if ($urandom_range(0, 9) == 0)
                send_random_access();
        end
        if ($urandom_range(0, 2) == 0)
            bus_read(($urandom_range(0, 1) != 0) ? scp_pkg::OFF_RAW : scp_pkg::OFF_MIS,
                     scp_pkg::LEN_HALF);
        if ($urandom_range(0, 3) == 0)
            bus_write(scp_pkg::OFF_ICLR, scp_pkg::LEN_HALF, 16'($urandom()));
    endtask

    task automatic test_reset_state();
        bus_read(scp_pkg::OFF_STATUS, scp_pkg::LEN_HALF);
        bus_read(scp_pkg::OFF_RAW, scp_pkg::LEN_HALF);
        exchange_frame(16'hFFFF);
    endtask

    task automatic test_register_file();
        bus_write(scp_pkg::OFF_CTRL0, scp_pkg::LEN_HALF, 16'hFFFF);
        bus_write(scp_pkg::OFF_PRESC, scp_pkg::LEN_BYTE, 16'hFFFF);
        bus_write(scp_pkg::OFF_CTRL1, scp_pkg::LEN_HALF, 16'h000F);
        bus_write(scp_pkg::OFF_IMASK, scp_pkg::LEN_HALF, 16'h00FF);
        bus_write(scp_pkg::OFF_DMA, scp_pkg::LEN_HALF, 16'hFFFF);
        bus_read(scp_pkg::OFF_PRESC, scp_pkg::LEN_HALF);
    endtask

    task automatic test_identity_and_errors();
        scp_pkg::req_t rq;
        bus_read(OFF_PID0 + 12'h00C, scp_pkg::LEN_HALF);
        bus_read(OFF_CID0, scp_pkg::LEN_BYTE);
        bus_read(scp_pkg::OFF_LIMIT + 12'h003, scp_pkg::LEN_HALF);
        bus_write(scp_pkg::OFF_CTRL0, scp_pkg::LEN_BAD, 16'h0000);
        bus_write(scp_pkg::OFF_STATUS, scp_pkg::LEN_HALF, 16'hFFFF);
        bus_write(OFF_UNUSED, scp_pkg::LEN_HALF, 16'hFFFF);
        bus_read(OFF_UNUSED, scp_pkg::LEN_HALF);
        rq = '0;
        rq.operation = OP_NOP;
        send_beat(rq);
    endtask

    task automatic test_frame_exchange();
        bus_write(scp_pkg::OFF_DATA, scp_pkg::LEN_HALF, 16'hFFFF);
        bus_write(scp_pkg::OFF_DATA, LEN_NONE, 16'h1234);
        exchange_frame(16'hFFFF);
        bus_write(scp_pkg::OFF_CTRL0, scp_pkg::LEN_HALF, 16'h0000);
        bus_write(scp_pkg::OFF_PRESC, scp_pkg::LEN_HALF, 16'h0000);
        exchange_frame(16'hFFFF);
        exchange_frame(16'hFFFF);
        bus_read(scp_pkg::OFF_DATA, scp_pkg::LEN_HALF);
        bus_read(scp_pkg::OFF_DATA, scp_pkg::LEN_BYTE);
        bus_read(scp_pkg::OFF_DATA, scp_pkg::LEN_HALF);
        bus_read(scp_pkg::OFF_MIS, scp_pkg::LEN_HALF);
        bus_write(scp_pkg::OFF_ICLR, scp_pkg::LEN_HALF, 16'h0003);
    endtask

    task automatic test_output_stall();
        stall_request = 1'b1;
        bus_write(scp_pkg::OFF_CTRL1, scp_pkg::LEN_HALF, 16'h0002);
        repeat (10)
            bus_write(scp_pkg::OFF_DATA, scp_pkg::LEN_HALF, 16'($urandom()));
        repeat (10)
            exchange_frame(16'($urandom()));
    endtask

    task automatic test_random_traffic();
        int r;
        while (beats_sent < RANDOM_BEATS)
        begin
            gaps_on = $urandom_range(0, 4) != 0;
            r = $urandom_range(0, 99);
            if (r < 30)
                repeat ($urandom_range(1, 8)) send_random_access();
            else if (r < 90)
                run_frame_burst();
            else
            begin
                bus_write(scp_pkg::OFF_IMASK, random_length(), 16'($urandom()));
                bus_write(scp_pkg::OFF_DMA, random_length(), 16'($urandom()));
                bus_read(scp_pkg::OFF_DMA, random_length());
                bus_read(scp_pkg::OFF_IMASK, random_length());
            end
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin : response_sink
        int  run_left;
        int  hold_left;
        logic ready_now;
        run_left = 0;
        hold_left = 0;
        ready_now = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                response_ready <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    if ($urandom_range(0, 99) < 65)
                    begin
                        ready_now = 1'b1;
                        run_left = $urandom_range(1, 30);
                    end
                    else
                    begin
                        ready_now = 1'b0;
                        run_left = pick_gap() + 1;
                    end
                end
                run_left--;
                response_ready <= ready_now;
            end
        end
    end

    task automatic compare_field(input string name, input logic [19:0] want,
                                 input logic [19:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : response_check
        scp_pkg::rsp_t want;
        if (rst_n && response_valid && response_ready)
        begin
            if (awaited_responses.size() == 0)
            begin
                $display("%0t: unexpected response beat, expected none, actual %h",
                         $time, response);
                errors++;
            end
            else
            begin
                want = awaited_responses.pop_front();
                compare_field("response_error", want.response_error, response.response_error);
                compare_field("read_data", want.read_data, response.read_data);
                compare_field("frame_sent", want.frame_sent, response.frame_sent);
                compare_field("sent_word", want.sent_word, response.sent_word);
                compare_field("frame_clocks", want.frame_clocks, response.frame_clocks);
                compare_field("interrupt_line", want.interrupt_line, response.interrupt_line);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((request_valid && request_ready) || (response_valid && response_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        clear_model();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_register_file();
        test_identity_and_errors();
        test_frame_exchange();
        test_output_stall();
        test_random_traffic();
        @(negedge clk);
        request_valid <= 1'b0;
        while (awaited_responses.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0 && awaited_responses.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
